// ===== design/micng_pkg.sv =====
package micng_pkg;

  localparam int RAW_W      = 16;
  localparam int CODE_W     = 12;
  localparam int SAMP_W     = 16;
  localparam int MAG_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int ALPHA_W    = 17;
  localparam int STEP_W     = 16;
  localparam int LEVEL_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int AVERAGE_TAPS = 8;
  localparam int TAP_AW       = $clog2(AVERAGE_TAPS);
  localparam int MV_W         = 12;
  localparam int SUM_W        = MV_W + TAP_AW;

  localparam int MV_SCALE    = 3300;
  localparam int MV_DIV      = 4095;
  localparam int MV_DIV_SH   = 12;
  localparam int MV_CENTER   = 1650;
  localparam int PROD_W      = 24;
  localparam int RECIP_W     = PROD_W + MV_DIV_SH + 1;
  localparam int RECIP_SHIFT = 24;
  localparam int Q_W         = 12;

  localparam int GAIN_SHIFT = 8;
  localparam int GAIN_RND   = (1 << GAIN_SHIFT) - 1;
  localparam int AVG_PROD_W = MV_W + GAIN_W + 1;
  localparam int CUR_W      = 20;
  localparam int SV_W       = CUR_W + 1;

  localparam int DC_W     = 32;
  localparam int DC_SHIFT = 16;
  localparam int DIFF_W   = CUR_W + DC_SHIFT + 1;
  localparam int HI_W     = DIFF_W - DC_SHIFT + ALPHA_W + 1;
  localparam int LO_W     = DC_SHIFT + ALPHA_W;
  localparam int DCSUM_W  = HI_W + 2;

  localparam int GATE_SHIFT = 15;
  localparam int GATE_RND   = (1 << GATE_SHIFT) - 1;
  localparam int GPROD_W    = SAMP_W + LEVEL_W + 1;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1 << GATE_SHIFT);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd6;

  typedef struct packed {
    logic               enable;
    logic [GAIN_W-1:0]  gain;
    logic [ALPHA_W-1:0] alpha;
    logic [MAG_W-1:0]   open_th;
    logic [MAG_W-1:0]   close_th;
    logic [STEP_W-1:0]  atk_step;
    logic [STEP_W-1:0]  rel_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:   1'b0,
    gain:     16'd256,
    alpha:    17'd66,
    open_th:  15'd1000,
    close_th: 15'd500,
    atk_step: 16'd328,
    rel_step: 16'd33
  };

  typedef struct packed {
    logic push;
    logic zero;
    logic last;
  } blk_req_t;

  typedef enum logic [3:0] {
    C_IDLE, C_DIV, C_MV, C_SUM, C_GAIN, C_CUR, C_DIFF, C_LO, C_HI, C_DCUP, C_OUT, C_DONE
  } cond_st_t;

  typedef enum logic [1:0] {
    E_IDLE, E_RD, E_MUL, E_PUT
  } emit_st_t;

endpackage

// ===== design/micng_if.sv =====
interface micng_in_if import micng_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_word;
  logic              last_in_block;

  modport source (output valid, raw_word, last_in_block, input ready);
  modport sink   (input valid, raw_word, last_in_block, output ready);
endinterface

interface micng_out_if import micng_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] sample_out;
  logic                     last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink   (input valid, sample_out, last_out, output ready);
endinterface

interface micng_cfg_if import micng_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/micng_cond.sv =====
module micng_cond
  import micng_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [CODE_W-1:0]        code,
  input  cfg_t                     cfg,
  output logic                     idle,
  output logic                     done,
  output logic signed [SAMP_W-1:0] samp
);

  cond_st_t state_r, state_nxt;

  logic signed [MV_W-1:0] win_mem [AVERAGE_TAPS];
  logic [AVERAGE_TAPS-1:0] win_vld_r, win_vld_nxt;
  logic [TAP_AW-1:0]       widx_r, widx_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [DC_W-1:0]  dc_r, dc_nxt;
  logic                    win_re, win_we;

  logic signed [MV_W-1:0]       old_r;
  logic                         old_vld_r;
  logic [PROD_W-1:0]            p_r;
  logic [Q_W-1:0]               q_r;
  logic signed [MV_W-1:0]       mv_r;
  logic signed [AVG_PROD_W-1:0] aprod_r;
  logic signed [CUR_W-1:0]      cur_r;
  logic signed [DIFF_W-1:0]     diff_r;
  logic [ALPHA_W-1:0]           lo_r;
  logic signed [HI_W-1:0]       hi_r;
  logic signed [SAMP_W-1:0]     s_r;

  logic [PROD_W-1:0]            p_calc;
  logic [RECIP_W-1:0]           recip_sum;
  logic [PROD_W-1:0]            rem;
  logic [Q_W-1:0]               q_fix;
  logic signed [MV_W:0]         mv_wide;
  logic signed [MV_W-1:0]       old_s;
  logic signed [SUM_W-1:0]      sum_calc;
  logic signed [SUM_W-1:0]      avg_bias;
  logic signed [SUM_W-1:0]      avg_full;
  logic signed [MV_W-1:0]       avg;
  logic signed [AVG_PROD_W-1:0] aprod_calc;
  logic signed [AVG_PROD_W-1:0] aprod_bias;
  logic signed [AVG_PROD_W-1:0] cur_full;
  logic signed [DIFF_W-1:0]     diff_calc;
  logic [LO_W-1:0]              lo_calc;
  logic signed [HI_W-1:0]       hi_calc;
  logic signed [DCSUM_W-1:0]    dsum;
  logic signed [DC_W-1:0]       dc_sat;
  logic signed [SV_W-1:0]       sv;
  logic signed [SAMP_W-1:0]     s_sat;

  assign p_calc    = PROD_W'(code) * PROD_W'(MV_SCALE);
  assign recip_sum = RECIP_W'(p_r) + (RECIP_W'(p_r) << MV_DIV_SH);
  assign rem       = p_r - ((PROD_W'(q_r) << MV_DIV_SH) - PROD_W'(q_r));
  assign q_fix     = q_r + Q_W'(rem >= PROD_W'(MV_DIV));
  assign mv_wide   = $signed({1'b0, q_fix}) - (MV_W + 1)'(MV_CENTER);

  assign old_s    = old_vld_r ? old_r : '0;
  assign sum_calc = sum_r - SUM_W'(old_s) + SUM_W'(mv_r);

  assign avg_bias   = sum_r[SUM_W-1] ? sum_r + SUM_W'(AVERAGE_TAPS - 1) : sum_r;
  assign avg_full   = avg_bias >>> TAP_AW;
  assign avg        = avg_full[MV_W-1:0];
  assign aprod_calc = AVG_PROD_W'(avg) * AVG_PROD_W'($signed({1'b0, cfg.gain}));

  assign aprod_bias = aprod_r[AVG_PROD_W-1] ? aprod_r + AVG_PROD_W'(GAIN_RND) : aprod_r;
  assign cur_full   = aprod_bias >>> GAIN_SHIFT;

  assign diff_calc = (DIFF_W'(cur_r) <<< DC_SHIFT) - DIFF_W'(dc_r);
  assign lo_calc   = LO_W'(diff_r[DC_SHIFT-1:0]) * LO_W'(cfg.alpha);
  assign hi_calc   = HI_W'(diff_r >>> DC_SHIFT) * HI_W'($signed({1'b0, cfg.alpha}));

  assign dsum = DCSUM_W'(hi_r) + DCSUM_W'($signed({1'b0, lo_r})) + DCSUM_W'(dc_r);

  always_comb begin
    if (dsum[DCSUM_W-1:DC_W-1] == {(DCSUM_W - DC_W + 1){dsum[DCSUM_W-1]}}) begin
      dc_sat = dsum[DC_W-1:0];
    end else if (dsum[DCSUM_W-1]) begin
      dc_sat = {1'b1, {(DC_W - 1){1'b0}}};
    end else begin
      dc_sat = {1'b0, {(DC_W - 1){1'b1}}};
    end
  end

  assign sv = SV_W'(cur_r) - SV_W'(dc_r >>> DC_SHIFT);

  always_comb begin
    if (sv[SV_W-1:SAMP_W-1] == {(SV_W - SAMP_W + 1){sv[SV_W-1]}}) begin
      s_sat = sv[SAMP_W-1:0];
    end else if (sv[SV_W-1]) begin
      s_sat = {1'b1, {(SAMP_W - 1){1'b0}}};
    end else begin
      s_sat = {1'b0, {(SAMP_W - 1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    win_vld_nxt = win_vld_r;
    widx_nxt    = widx_r;
    sum_nxt     = sum_r;
    dc_nxt      = dc_r;
    win_re      = 1'b0;
    win_we      = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          win_re    = 1'b1;
          state_nxt = C_DIV;
        end
      end
      C_DIV:  state_nxt = C_MV;
      C_MV:   state_nxt = C_SUM;
      C_SUM: begin
        win_we              = 1'b1;
        win_vld_nxt[widx_r] = 1'b1;
        widx_nxt            = widx_r + TAP_AW'(1);
        sum_nxt             = sum_calc;
        state_nxt           = C_GAIN;
      end
      C_GAIN: state_nxt = C_CUR;
      C_CUR:  state_nxt = C_DIFF;
      C_DIFF: state_nxt = C_LO;
      C_LO:   state_nxt = C_HI;
      C_HI:   state_nxt = C_DCUP;
      C_DCUP: begin
        dc_nxt    = dc_sat;
        state_nxt = C_OUT;
      end
      C_OUT:  state_nxt = C_DONE;
      C_DONE: state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= C_IDLE;
      win_vld_r <= '0;
      widx_r    <= '0;
      sum_r     <= '0;
      dc_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      win_vld_r <= win_vld_nxt;
      widx_r    <= widx_nxt;
      sum_r     <= sum_nxt;
      dc_r      <= dc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[widx_r] <= mv_r;
    end
    if (win_re) begin
      old_r     <= win_mem[widx_r];
      old_vld_r <= win_vld_r[widx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) p_r <= p_calc;
    if (state_r == C_DIV)  q_r     <= recip_sum[RECIP_SHIFT +: Q_W];
    if (state_r == C_MV)   mv_r    <= mv_wide[MV_W-1:0];
    if (state_r == C_GAIN) aprod_r <= aprod_calc;
    if (state_r == C_CUR)  cur_r   <= cur_full[CUR_W-1:0];
    if (state_r == C_DIFF) diff_r  <= diff_calc;
    if (state_r == C_LO)   lo_r    <= lo_calc[LO_W-1:DC_SHIFT];
    if (state_r == C_HI)   hi_r    <= hi_calc;
    if (state_r == C_OUT)  s_r     <= s_sat;
  end

  assign idle = (state_r == C_IDLE);
  assign done = (state_r == C_DONE);
  assign samp = s_r;

endmodule

// ===== design/micng_blk.sv =====
module micng_blk
  import micng_pkg::*;
#(
  parameter int BLOCK_MAX = 64
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  blk_req_t                 req,
  input  logic signed [SAMP_W-1:0] samp,
  input  cfg_t                     cfg,
  output logic                     idle,
  micng_out_if.source              out_if
);

  localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
  localparam int ADDR_W = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;

  emit_st_t state_r, state_nxt;

  logic signed [SAMP_W-1:0] store [BLOCK_MAX];

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [MAG_W-1:0]   peak_r, peak_nxt;
  logic               open_r, open_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               zmode_r, zmode_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic                      zlast_r;
  logic signed [SAMP_W-1:0]  rd_r;
  logic signed [GPROD_W-1:0] gprod_r;
  logic signed [SAMP_W-1:0]  out_samp_r;
  logic                      out_last_r;

  logic               st_we, st_re, load;
  logic [SAMP_W-1:0]  abs_w;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   peak_new;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   k_inc;
  logic               blk_end;
  logic               open_new;
  logic               last_k;
  logic [LEVEL_W:0]   level_up;
  logic [LEVEL_W-1:0] level_ramp;

  logic signed [GPROD_W-1:0] gbias;
  logic signed [GPROD_W-1:0] gfull;

  assign abs_w    = samp[SAMP_W-1] ? (~samp + SAMP_W'(1)) : samp;
  assign mag      = abs_w[SAMP_W-1] ? {MAG_W{1'b1}} : abs_w[MAG_W-1:0];
  assign peak_new = (mag > peak_r) ? mag : peak_r;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign blk_end  = req.last || (cnt_inc == CNT_W'(BLOCK_MAX));
  assign k_inc    = k_r + CNT_W'(1);
  assign last_k   = (k_inc == n_r);

  always_comb begin
    if (!open_r && peak_new > cfg.open_th) begin
      open_new = 1'b1;
    end else if (open_r && peak_new < cfg.close_th) begin
      open_new = 1'b0;
    end else begin
      open_new = open_r;
    end
  end

  assign level_up = (LEVEL_W + 1)'(level_r) + (LEVEL_W + 1)'(cfg.atk_step);

  always_comb begin
    level_ramp = level_r;
    if (open_r && level_r < LEVEL_ONE) begin
      level_ramp = (level_up > (LEVEL_W + 1)'(LEVEL_ONE)) ? LEVEL_ONE : level_up[LEVEL_W-1:0];
    end else if (!open_r && level_r != '0) begin
      level_ramp = (LEVEL_W'(cfg.rel_step) >= level_r) ? '0 : level_r - LEVEL_W'(cfg.rel_step);
    end
  end

  assign gbias = gprod_r[GPROD_W-1] ? gprod_r + GPROD_W'(GATE_RND) : gprod_r;
  assign gfull = gbias >>> GATE_SHIFT;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    peak_nxt      = peak_r;
    open_nxt      = open_r;
    level_nxt     = level_r;
    zmode_nxt     = zmode_r;
    out_valid_nxt = out_valid_r;
    st_we         = 1'b0;
    st_re         = 1'b0;
    load          = 1'b0;
    if (out_if.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      E_IDLE: begin
        if (req.push) begin
          st_we = 1'b1;
          if (blk_end) begin
            open_nxt  = open_new;
            n_nxt     = cnt_inc;
            k_nxt     = '0;
            cnt_nxt   = '0;
            peak_nxt  = '0;
            zmode_nxt = 1'b0;
            state_nxt = E_RD;
          end else begin
            cnt_nxt  = cnt_inc;
            peak_nxt = peak_new;
          end
        end else if (req.zero) begin
          zmode_nxt = 1'b1;
          state_nxt = E_PUT;
        end
      end
      E_RD: begin
        st_re     = 1'b1;
        level_nxt = level_ramp;
        state_nxt = E_MUL;
      end
      E_MUL: state_nxt = E_PUT;
      E_PUT: begin
        if (!out_valid_r || out_if.ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          if (zmode_r || last_k) begin
            state_nxt = E_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = E_RD;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      k_r         <= '0;
      peak_r      <= '0;
      open_r      <= 1'b0;
      level_r     <= '0;
      zmode_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      peak_r      <= peak_nxt;
      open_r      <= open_nxt;
      level_r     <= level_nxt;
      zmode_r     <= zmode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[cnt_r[ADDR_W-1:0]] <= samp;
    end
    if (st_re) begin
      rd_r <= store[k_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == E_IDLE && req.zero) zlast_r <= req.last;
    if (state_r == E_MUL) begin
      gprod_r <= GPROD_W'(rd_r) * GPROD_W'($signed({1'b0, level_r}));
    end
    if (load) begin
      out_samp_r <= zmode_r ? '0 : gfull[SAMP_W-1:0];
      out_last_r <= zmode_r ? zlast_r : last_k;
    end
  end

  assign idle              = (state_r == E_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_samp_r;
  assign out_if.last_out   = out_last_r;

endmodule

// ===== design/mic_adc_conditioner_noise_gate_top.sv =====
// Channel  Dir  Payload                            Transfer when
// in_if    in   raw_word[15:0], last_in_block      valid && ready
// out_if   out  sample_out[15:0] signed, last_out  valid && ready
// cfg_if   in   index[2:0], data[16:0]             valid && ready (ready held high)
//
// An enabled sample is written to the block memory after the conditioner steps (divide,
// window memory, gain multiply, two DC partial products, saturate); in_if reopens once
// both units are idle. A block end drains the block memory one result at a time: read,
// gate multiply, put. A disabled sample moves the block unit to its put state, which loads
// its zero result into the output register once out_if does not stall.
// rst_n is synchronous: gate closed, gate level, window, average and DC state cleared.
// A stalled out_if holds the output register and the drain; in_if waits for both units.
module mic_adc_conditioner_noise_gate_top
  import micng_pkg::*;
#(
  parameter int BLOCK_MAX = 64
)
(
  input  logic        clk,
  input  logic        rst_n,
  micng_in_if.sink    in_if,
  micng_out_if.source out_if,
  micng_cfg_if.sink   cfg_if
);

  cfg_t     cfg_r, cfg_nxt;
  logic     last_r;
  logic     acc;
  logic     cond_idle, cond_done;
  logic     blk_idle;
  blk_req_t req;

  logic signed [SAMP_W-1:0] cond_samp;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        REG_ENABLE:  cfg_nxt.enable   = cfg_if.data[0];
        REG_GAIN:    cfg_nxt.gain     = cfg_if.data[GAIN_W-1:0];
        REG_ALPHA:   cfg_nxt.alpha    = cfg_if.data[ALPHA_W-1:0];
        REG_OPEN:    cfg_nxt.open_th  = cfg_if.data[MAG_W-1:0];
        REG_CLOSE:   cfg_nxt.close_th = cfg_if.data[MAG_W-1:0];
        REG_ATTACK:  cfg_nxt.atk_step = cfg_if.data[STEP_W-1:0];
        REG_RELEASE: cfg_nxt.rel_step = cfg_if.data[STEP_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_if.ready = cond_idle && blk_idle;
  assign acc         = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (acc) last_r <= in_if.last_in_block;
  end

  assign req.push = cond_done;
  assign req.zero = acc && !cfg_r.enable;
  assign req.last = req.zero ? in_if.last_in_block : last_r;

  micng_cond u_cond (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc && cfg_r.enable),
    .code  (in_if.raw_word[CODE_W-1:0]),
    .cfg   (cfg_r),
    .idle  (cond_idle),
    .done  (cond_done),
    .samp  (cond_samp)
  );

  micng_blk #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_blk (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .samp   (cond_samp),
    .cfg    (cfg_r),
    .idle   (blk_idle),
    .out_if (out_if)
  );

endmodule
